// ===== hdl/buddy_allocator_assert.svh =====
// Assertion macros for the buddy allocator checks.
// Expects clk and rst_n in the scope of each use.
`ifndef BUDDY_ALLOCATOR_ASSERT_SVH
`define BUDDY_ALLOCATOR_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define BA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator same-cycle check failed");

// Check a consequence in the cycle after its cause
`define BA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator next-cycle check failed");

`endif

// ===== hdl/ba_pkg.sv =====
// Shared constants, types and helpers of the buddy allocator.
// No dependencies; used by every module of the block.
package ba_pkg;

  localparam int TABLE_ENTRIES   = 512;
  localparam int IDX_W           = $clog2(TABLE_ENTRIES);
  localparam int MIN_BLOCK_BYTES = 32;
  localparam int MIN_SHIFT       = $clog2(MIN_BLOCK_BYTES);
  localparam int HEAP_BYTES      = TABLE_ENTRIES * MIN_BLOCK_BYTES;
  localparam int ENTRY_W         = 16;
  localparam int LEVELS          = IDX_W + 1;
  localparam int LVL_W           = $clog2(LEVELS);
  localparam int ADDR_W          = 32;
  localparam int SIZE_W          = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic [ENTRY_W-1:0] USED_BIT      = ENTRY_W'(1);
  localparam logic [ENTRY_W-1:0] HEAP_ENTRY    = ENTRY_W'(HEAP_BYTES);
  localparam logic [ADDR_W-1:0]  HEAP_BASE_RST = 32'h2000_1000;
  localparam logic [ADDR_W-1:0]  FREE_SPAN     = ADDR_W'(HEAP_BYTES - MIN_BLOCK_BYTES);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Decoded request word passed from front to back
  typedef struct packed {
    op_t               op;
    logic              fail;
    logic [LVL_W-1:0]  level;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

  // Bytes of a block that spans 2**lvl minimum blocks
  function automatic logic [ENTRY_W-1:0] block_bytes(input logic [LVL_W-1:0] lvl);
    block_bytes = ENTRY_W'(MIN_BLOCK_BYTES) << lvl;
  endfunction

endpackage

// ===== hdl/ba_front.sv =====
// Request front end: accepts a word, rounds and classifies it.
// Depends on ba_pkg; feeds ba_queue.
module ba_front (
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_operation,
  input  logic [ba_pkg::SIZE_W-1:0] in_request_size,
  input  logic [ba_pkg::ADDR_W-1:0] in_free_address,
  input  logic [ba_pkg::ADDR_W-1:0] heap_base,
  input  ba_pkg::q_status_t         q_status,
  input  ba_pkg::bk_status_t        bk_status,
  output logic                      push,
  output ba_pkg::cmd_t              cmd
);

  logic [ba_pkg::SIZE_W-1:0]  size_rnd;
  logic                       oversize;
  logic [ba_pkg::LVL_W-1:0]   level;
  logic [ba_pkg::ADDR_W:0]    diff;
  logic                       in_range;

  // Hold off while the queue is full or the table is being cleared
  assign busy = q_status.full | bk_status.clearing;
  assign push = start & ~busy;

  // Round the size up to one minimum block
  assign size_rnd = (in_request_size < ba_pkg::SIZE_W'(ba_pkg::MIN_BLOCK_BYTES)) ?
                    ba_pkg::SIZE_W'(ba_pkg::MIN_BLOCK_BYTES) : in_request_size;
  assign oversize = ({1'b0, size_rnd} > (ba_pkg::SIZE_W+1)'(ba_pkg::HEAP_BYTES));

  // Pick the smallest tree level whose block holds the size
  always_comb begin
    level = '0;
    for (int k = ba_pkg::IDX_W; k >= 0; k--) begin
      if (ba_pkg::block_bytes(ba_pkg::LVL_W'(k)) >= size_rnd) begin
        level = ba_pkg::LVL_W'(k);
      end
    end
  end

  // Range check of the free address against the heap
  assign diff     = {1'b0, in_free_address} - {1'b0, heap_base};
  assign in_range = ~diff[ba_pkg::ADDR_W] && (diff[ba_pkg::ADDR_W-1:0] <= ba_pkg::FREE_SPAN);

  always_comb begin
    cmd.op    = ba_pkg::op_t'(in_operation);
    cmd.fail  = (cmd.op == ba_pkg::OP_ALLOC) ? oversize : ~in_range;
    cmd.level = level;
    cmd.idx   = diff[ba_pkg::MIN_SHIFT +: ba_pkg::IDX_W];
    cmd.addr  = in_free_address;
  end

endmodule

// ===== hdl/ba_queue.sv =====
// Short request queue between front end and table engine.
// Depends on ba_pkg.
module ba_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ba_pkg::cmd_t      cmd_in,
  input  logic              pop,
  output ba_pkg::cmd_t      cmd_out,
  output ba_pkg::q_status_t status
);

  ba_pkg::cmd_t              slot_r [ba_pkg::QUEUE_DEPTH];
  logic [ba_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ba_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ba_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == (ba_pkg::QPTR_W+1)'(ba_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign cmd_out      = slot_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ba_pkg::QPTR_W'(ba_pkg::QUEUE_DEPTH-1)) ? '0 :
                   wr_ptr_r + ba_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ba_pkg::QPTR_W'(ba_pkg::QUEUE_DEPTH-1)) ? '0 :
                   rd_ptr_r + ba_pkg::QPTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + (ba_pkg::QPTR_W+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (ba_pkg::QPTR_W+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== hdl/ba_back.sv =====
// Table engine: owns the control table, runs searches, splits and merges.
// Depends on ba_pkg; takes words from ba_queue.
module ba_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ba_pkg::q_status_t         q_status,
  input  ba_pkg::cmd_t              q_cmd,
  output logic                      q_pop,
  input  logic [ba_pkg::ADDR_W-1:0] heap_base,
  output ba_pkg::bk_status_t        bk_status,
  output logic                      out_valid,
  output logic [ba_pkg::ADDR_W-1:0] out_block_address,
  output logic                      out_success
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_M_RD, S_M_CHK,
    S_F_RD, S_F_CHK, S_B_RD, S_B_CHK, S_B_WR
  } state_t;

  localparam int BLK_W = ba_pkg::ENTRY_W - ba_pkg::MIN_SHIFT;

  // Control table
  logic [ba_pkg::ENTRY_W-1:0] mem [ba_pkg::TABLE_ENTRIES];
  logic [ba_pkg::ENTRY_W-1:0] rd_data_r;
  logic                       mem_we;
  logic [ba_pkg::IDX_W-1:0]   mem_waddr;
  logic [ba_pkg::ENTRY_W-1:0] mem_wdata;
  logic [ba_pkg::IDX_W-1:0]   mem_raddr;

  state_t                     state_r, state_nxt;
  ba_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [ba_pkg::IDX_W-1:0]   lo_r, lo_nxt;
  logic [ba_pkg::LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [ba_pkg::ENTRY_W-1:0] size_r, size_nxt;
  logic [ba_pkg::IDX_W-1:0]   bud_r, bud_nxt;
  logic [ba_pkg::IDX_W-1:0]   clr_r, clr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [ba_pkg::ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic                       out_succ_r, out_succ_nxt;

  logic [ba_pkg::ENTRY_W-1:0] leaf_bytes;
  logic [ba_pkg::IDX_W:0]     lo_ext, step, leaf_next, mid_ext;
  logic                       a_hit, walk_done;
  logic [ba_pkg::IDX_W-1:0]   mid;
  logic [BLK_W-1:0]           blocks, lo_w, buddy_dn;
  logic [BLK_W:0]             buddy_up;
  logic                       odd, brk;
  logic [ba_pkg::IDX_W-1:0]   buddy;
  logic [ba_pkg::ENTRY_W-1:0] f_size;
  logic [ba_pkg::ADDR_W-1:0]  alloc_addr;

  assign bk_status.clearing = (state_r == S_CLEAR);
  assign q_pop              = (state_r == S_IDLE) && !q_status.empty;
  assign out_valid          = out_valid_r;
  assign out_block_address  = out_addr_r;
  assign out_success        = out_succ_r;

  // Search and split helpers
  assign leaf_bytes = ba_pkg::block_bytes(lvl_r);
  assign lo_ext     = {1'b0, lo_r};
  assign step       = (ba_pkg::IDX_W+1)'(1) << lvl_r;
  assign leaf_next  = lo_ext + step;
  assign a_hit      = ((rd_data_r & ba_pkg::USED_BIT) == '0) && (rd_data_r >= leaf_bytes);
  assign walk_done  = (lvl_r >= ba_pkg::LVL_W'(ba_pkg::IDX_W));
  assign mid_ext    = (lo_ext | step) & ~(step - (ba_pkg::IDX_W+1)'(1));
  assign mid        = mid_ext[ba_pkg::IDX_W-1:0];
  assign alloc_addr = heap_base + ba_pkg::ADDR_W'({lo_r, {ba_pkg::MIN_SHIFT{1'b0}}});

  // Merge helpers; block sizes are powers of two
  assign blocks   = size_r[ba_pkg::ENTRY_W-1:ba_pkg::MIN_SHIFT];
  assign lo_w     = BLK_W'(lo_r);
  assign odd      = |(lo_w & blocks);
  assign buddy_dn = lo_w - blocks;
  assign buddy_up = {1'b0, lo_w} + {1'b0, blocks};
  assign brk      = (blocks == '0) ||
                    (odd ? (lo_w < blocks) :
                     (buddy_up >= (BLK_W+1)'(ba_pkg::TABLE_ENTRIES)));
  assign buddy    = odd ? buddy_dn[ba_pkg::IDX_W-1:0] : buddy_up[ba_pkg::IDX_W-1:0];
  assign f_size   = rd_data_r & ~ba_pkg::USED_BIT;

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    lo_nxt        = lo_r;
    lvl_nxt       = lvl_r;
    size_nxt      = size_r;
    bud_nxt       = bud_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_addr_nxt  = out_addr_r;
    out_succ_nxt  = out_succ_r;
    mem_we        = 1'b0;
    mem_waddr     = lo_r;
    mem_wdata     = '0;
    mem_raddr     = lo_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = (clr_r == '0) ? ba_pkg::HEAP_ENTRY : '0;
        clr_nxt   = clr_r + ba_pkg::IDX_W'(1);
        if (clr_r == ba_pkg::IDX_W'(ba_pkg::TABLE_ENTRIES-1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_status.empty) begin
          cmd_nxt = q_cmd;
          if (q_cmd.fail) begin
            out_valid_nxt = 1'b1;
            out_addr_nxt  = '0;
            out_succ_nxt  = 1'b0;
          end else if (q_cmd.op == ba_pkg::OP_ALLOC) begin
            lo_nxt    = '0;
            lvl_nxt   = q_cmd.level;
            state_nxt = S_A_RD;
          end else begin
            lo_nxt    = q_cmd.idx;
            state_nxt = S_F_RD;
          end
        end
      end
      S_A_RD: begin
        mem_raddr = lo_r;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (a_hit) begin
          // Mark the block used, then walk up recording split-off buddies
          mem_we    = 1'b1;
          mem_waddr = lo_r;
          mem_wdata = leaf_bytes | ba_pkg::USED_BIT;
          state_nxt = S_M_RD;
        end else if (leaf_next[ba_pkg::IDX_W]) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_succ_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          lo_nxt    = leaf_next[ba_pkg::IDX_W-1:0];
          state_nxt = S_A_RD;
        end
      end
      S_M_RD: begin
        mem_raddr = mid;
        if (walk_done) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = alloc_addr;
          out_succ_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else if (lo_ext[lvl_r]) begin
          lvl_nxt = lvl_r + ba_pkg::LVL_W'(1);
        end else begin
          state_nxt = S_M_CHK;
        end
      end
      S_M_CHK: begin
        if ((rd_data_r & ba_pkg::USED_BIT) == '0) begin
          mem_we    = 1'b1;
          mem_waddr = mid;
          mem_wdata = leaf_bytes;
        end
        lvl_nxt   = lvl_r + ba_pkg::LVL_W'(1);
        state_nxt = S_M_RD;
      end
      S_F_RD: begin
        mem_raddr = lo_r;
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        if (f_size[ba_pkg::ENTRY_W-1:ba_pkg::MIN_SHIFT] == '0) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_succ_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = lo_r;
          mem_wdata = f_size;
          size_nxt  = f_size;
          state_nxt = S_B_RD;
        end
      end
      S_B_RD: begin
        mem_raddr = buddy;
        bud_nxt   = buddy;
        if (brk) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = cmd_r.addr;
          out_succ_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_B_CHK;
        end
      end
      S_B_CHK: begin
        if (((rd_data_r & ba_pkg::USED_BIT) != '0) || (rd_data_r != size_r)) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = cmd_r.addr;
          out_succ_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // Drop the upper half's entry, keep the lower as the merged block
          mem_we    = 1'b1;
          mem_waddr = (bud_r < lo_r) ? lo_r : bud_r;
          mem_wdata = '0;
          lo_nxt    = (bud_r < lo_r) ? bud_r : lo_r;
          size_nxt  = size_r << 1;
          state_nxt = S_B_WR;
        end
      end
      S_B_WR: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = size_r;
        state_nxt = S_B_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
      lo_r        <= lo_nxt;
      lvl_r       <= lvl_nxt;
      size_r      <= size_nxt;
      bud_r       <= bud_nxt;
      out_addr_r  <= out_addr_nxt;
      out_succ_r  <= out_succ_nxt;
    end
  end

  // Table write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

endmodule

// ===== hdl/buddy_allocator.sv =====
// Buddy allocator top level: config register, front end, queue, table engine.
// Depends on ba_pkg, ba_front, ba_queue, ba_back and buddy_allocator_assert.svh.
//
//  channel  handshake            payload
//  in       start / busy         in_operation, in_request_size, in_free_address
//  out      out_valid (strobe)   out_block_address, out_success
//  cfg      cfg_valid/cfg_ready  cfg_data (heap_base)
//
// Allocate: per candidate block scanned at the fitting level (up to 512 /
// blocks-per-candidate) S_A_RD and S_A_CHK, then per tree level of the split
// S_M_RD plus S_M_CHK for a lower half, all bound by the single table read
// port. Free: S_F_RD, S_F_CHK, then per merge S_B_RD, S_B_CHK and S_B_WR.
// After reset a clearing pass writes all 512 table entries with busy high.
// Reset is synchronous, active low. Two words queue ahead of the engine; results
// appear for one cycle and cannot be stalled.
`include "buddy_allocator_assert.svh"

module buddy_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_operation,
  input  logic [ba_pkg::SIZE_W-1:0] in_request_size,
  input  logic [ba_pkg::ADDR_W-1:0] in_free_address,
  output logic                      out_valid,
  output logic [ba_pkg::ADDR_W-1:0] out_block_address,
  output logic                      out_success,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ba_pkg::ADDR_W-1:0] cfg_data
);

  logic [ba_pkg::ADDR_W-1:0] heap_base_r;
  ba_pkg::q_status_t         q_status;
  ba_pkg::bk_status_t        bk_status;
  ba_pkg::cmd_t              push_cmd;
  ba_pkg::cmd_t              head_cmd;
  logic                      push;
  logic                      pop;

  // Heap base register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= ba_pkg::HEAP_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      heap_base_r <= cfg_data;
    end
  end

  ba_front u_front (
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_request_size (in_request_size),
    .in_free_address (in_free_address),
    .heap_base       (heap_base_r),
    .q_status        (q_status),
    .bk_status       (bk_status),
    .push            (push),
    .cmd             (push_cmd)
  );

  ba_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (push_cmd),
    .pop     (pop),
    .cmd_out (head_cmd),
    .status  (q_status)
  );

  ba_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_status          (q_status),
    .q_cmd             (head_cmd),
    .q_pop             (pop),
    .heap_base         (heap_base_r),
    .bk_status         (bk_status),
    .out_valid         (out_valid),
    .out_block_address (out_block_address),
    .out_success       (out_success)
  );

  // Failed results carry a zero address
  `BA_ASSERT_SAME(a_fail_zero, out_valid && !out_success, out_block_address == '0)
  // No result leaves while the table is being cleared
  `BA_ASSERT_SAME(a_quiet_clear, bk_status.clearing, !out_valid && busy)
  // An accepted word is waiting in the queue on the next cycle
  `BA_ASSERT_NEXT(a_push_held, start && !busy, !q_status.empty)

endmodule
